// ===== hw/rtl/wwl_pkg.sv =====
// Shared types and constants for the greedy word-wrap line indexer.
// Used by wwl_step, text_word_wrap_line_indexer_core and tb_top; depends on nothing.
package wwl_pkg;

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_SP = 8'h20;

  localparam int unsigned WRAP_W  = 8;
  localparam int unsigned LINES_W = 16;
  localparam int unsigned OFFS_W  = 18;

  localparam logic [WRAP_W-1:0]  WRAP_COLUMNS_RESET = 8'd29;
  localparam logic [LINES_W-1:0] MAX_LINES_RESET    = 16'd20000;

  // Configuration register indexes.
  localparam logic REG_WRAP_COLUMNS = 1'b0;
  localparam logic REG_MAX_LINES    = 1'b1;

  typedef struct packed {
    logic                new_line;
    logic [OFFS_W-1:0]   line_offset;
    logic [LINES_W-1:0]  line_index;
    logic                end_of_text;
    logic [LINES_W-1:0]  line_count;
  } result_t;

endpackage

// ===== hw/rtl/wwl_step.sv =====
// Next-state and result logic for one text byte of the word-wrap indexer.
// Depends on wwl_pkg; purely combinational, the state lives in the top level.
module wwl_step import wwl_pkg::*; #(
  parameter int unsigned PW = 19,
  parameter int unsigned MAX_TEXT_BYTES = 262144
) (
  input  logic [7:0]         text_byte,
  input  logic               last_byte,
  input  logic [WRAP_W-1:0]  wrap_columns,
  input  logic [LINES_W-1:0] max_lines,
  input  logic [PW-1:0]      byte_position,
  input  logic [PW-1:0]      current_line_start,
  input  logic [PW-1:0]      last_space_position,
  input  logic               space_seen,
  input  logic               line_pending,
  input  logic [LINES_W-1:0] lines_recorded,
  output logic [PW-1:0]      byte_position_next,
  output logic [PW-1:0]      current_line_start_next,
  output logic [PW-1:0]      last_space_position_next,
  output logic               space_seen_next,
  output logic               line_pending_next,
  output logic [LINES_W-1:0] lines_recorded_next,
  output result_t            result
);

  localparam logic [PW-1:0] MaxPos = PW'(MAX_TEXT_BYTES);

  logic              active;
  logic              is_space;
  logic              is_nl;
  logic [WRAP_W-1:0] cols;
  logic [PW-1:0]     cls_a;
  logic [PW-1:0]     lsp_b;
  logic              seen_b;
  logic [PW-1:0]     column;
  logic [PW-1:0]     space_dist;
  logic              do_wrap;
  logic              near_space;
  logic              rep_req;
  logic [PW-1:0]     rep_pos;
  logic              rep_ok;

  always_comb begin
    active   = byte_position < MaxPos;
    is_space = (text_byte == CHAR_SP) || (text_byte == CHAR_CR);
    is_nl    = (text_byte == CHAR_NL);
    cols     = (wrap_columns == '0) ? WRAP_W'(1) : wrap_columns;

    // A pending line starts at this byte.
    cls_a  = line_pending ? byte_position : current_line_start;
    seen_b = line_pending ? 1'b0 : space_seen;
    lsp_b  = line_pending ? '0 : last_space_position;
    if (!is_nl && is_space) begin
      seen_b = 1'b1;
      lsp_b  = byte_position;
    end

    column     = byte_position - cls_a;
    space_dist = byte_position - lsp_b;
    do_wrap    = !is_nl && (column >= PW'(cols));
    near_space = seen_b && (space_dist < PW'(cols >> 1));

    byte_position_next       = byte_position;
    current_line_start_next  = current_line_start;
    last_space_position_next = last_space_position;
    space_seen_next          = space_seen;
    line_pending_next        = line_pending;
    rep_req                  = 1'b0;
    rep_pos                  = byte_position;

    if (active) begin
      byte_position_next       = byte_position + PW'(1);
      current_line_start_next  = cls_a;
      last_space_position_next = lsp_b;
      space_seen_next          = seen_b;
      line_pending_next        = is_nl;
      rep_req                  = line_pending;
      if (do_wrap) begin
        if (near_space && (lsp_b == byte_position)) begin
          // The wrapping byte is itself the space: the next byte opens the line.
          line_pending_next = 1'b1;
        end else begin
          rep_req                  = 1'b1;
          rep_pos                  = near_space ? lsp_b + PW'(1) : byte_position;
          current_line_start_next  = rep_pos;
          space_seen_next          = 1'b0;
          last_space_position_next = '0;
        end
      end
    end

    rep_ok              = rep_req && (lines_recorded < max_lines);
    lines_recorded_next = rep_ok ? lines_recorded + LINES_W'(1) : lines_recorded;

    result.new_line    = rep_ok;
    result.line_offset = rep_ok ? OFFS_W'(rep_pos) : '0;
    result.line_index  = rep_ok ? lines_recorded : '0;
    result.end_of_text = last_byte;
    result.line_count  = last_byte ? lines_recorded_next : '0;

    if (last_byte) begin
      byte_position_next       = '0;
      current_line_start_next  = '0;
      last_space_position_next = '0;
      space_seen_next          = 1'b0;
      line_pending_next        = 1'b1;
      lines_recorded_next      = '0;
    end
  end

endmodule

// ===== hw/rtl/text_word_wrap_line_indexer_core.sv =====
// Greedy word-wrap line indexer: each accepted input passes the input register and then the
// result register, which holds its result until the output stream takes it. Throughput is
// one item per cycle while the output is not stalled. The byte state update is a single
// compare-and-subtract pass between the input and result registers, so nothing iterates.
// Reset (rst, synchronous) empties both pipeline registers, restores wrap_columns to 29,
// max_lines to 20000, and puts the line state at its start with a line pending.
// Top level; depends on wwl_pkg and wwl_step.
module text_word_wrap_line_indexer_core import wwl_pkg::*; #(
  parameter int unsigned MAX_TEXT_BYTES = 262144
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] text_byte
  input  logic         s_tlast,   // last_byte
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,   // [17:0] line_offset, [33:18] line_index,
                                  // [49:34] line_count, [55:50] zero
  output logic         m_tuser,   // new_line
  output logic         m_tlast    // end_of_text
);

  // Positions must hold the byte limit itself, where counting stops.
  localparam int unsigned PW = $clog2(MAX_TEXT_BYTES + 1);

  // Configuration registers.
  logic [WRAP_W-1:0]  wrap_columns;
  logic [LINES_W-1:0] max_lines;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_columns <= WRAP_COLUMNS_RESET;
      max_lines    <= MAX_LINES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WRAP_COLUMNS: wrap_columns <= cfg_data[WRAP_W-1:0];
        REG_MAX_LINES:    max_lines    <= cfg_data[LINES_W-1:0];
        default:          ;
      endcase
    end
  end

  // The pipeline moves as a whole when the result register is free or being
  // drained. The input register takes a new item whenever it is empty or
  // about to hand its item on, so bytes stream one per cycle while the output is not stalled.
  logic    in_valid;
  logic    advance;
  logic [7:0] in_byte;
  logic    in_last;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Line state, updated once per item as it leaves the input register.
  logic [PW-1:0]      byte_position,       byte_position_next;
  logic [PW-1:0]      current_line_start,  current_line_start_next;
  logic [PW-1:0]      last_space_position, last_space_position_next;
  logic               space_seen,          space_seen_next;
  logic               line_pending,        line_pending_next;
  logic [LINES_W-1:0] lines_recorded,      lines_recorded_next;
  result_t            step_result;
  result_t            out_result;
  logic               consume;

  wwl_step #(
    .PW             (PW),
    .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
  ) u_step (
    .text_byte                (in_byte),
    .last_byte                (in_last),
    .wrap_columns             (wrap_columns),
    .max_lines                (max_lines),
    .byte_position            (byte_position),
    .current_line_start       (current_line_start),
    .last_space_position      (last_space_position),
    .space_seen               (space_seen),
    .line_pending             (line_pending),
    .lines_recorded           (lines_recorded),
    .byte_position_next       (byte_position_next),
    .current_line_start_next  (current_line_start_next),
    .last_space_position_next (last_space_position_next),
    .space_seen_next          (space_seen_next),
    .line_pending_next        (line_pending_next),
    .lines_recorded_next      (lines_recorded_next),
    .result                   (step_result)
  );

  assign consume = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      current_line_start  <= '0;
      last_space_position <= '0;
      space_seen          <= 1'b0;
      line_pending        <= 1'b1;
      lines_recorded      <= '0;
    end else if (consume) begin
      byte_position       <= byte_position_next;
      current_line_start  <= current_line_start_next;
      last_space_position <= last_space_position_next;
      space_seen          <= space_seen_next;
      line_pending        <= line_pending_next;
      lines_recorded      <= lines_recorded_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {6'b0, out_result.line_count, out_result.line_index,
                    out_result.line_offset};
  assign m_tuser = out_result.new_line;
  assign m_tlast = out_result.end_of_text;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for text_word_wrap_line_indexer_core: directed table, random texts,
// and one long text past the byte limit. Depends on wwl_pkg and the core RTL only.
module tb_top;
  import wwl_pkg::*;

  localparam int unsigned TEXT_LIMIT = 1024;
  // Cycles without any handshake or register write before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] text_byte
  logic        s_tlast = 1'b0;  // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;         // [17:0] line_offset, [33:18] line_index, [49:34] line_count
  logic        m_tuser;         // new_line
  logic        m_tlast;         // end_of_text

  text_word_wrap_line_indexer_core #(.MAX_TEXT_BYTES(TEXT_LIMIT)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line-start predictor. It mirrors the wrap rules with its own copy of the
  // registers and the per-byte state, updated at every accepted item.
  // ---------------------------------------------------------------------------
  logic [7:0]  wrap_cols;
  logic [15:0] line_cap;
  int unsigned text_pos;
  int unsigned line_base;
  int unsigned space_pos;
  bit          space_found;
  bit          start_due;
  int unsigned lines_done;

  result_t line_starts_q[$];  // expected results, oldest first

  task automatic restart_text();
    text_pos    = 0;
    line_base   = 0;
    space_pos   = 0;
    space_found = 1'b0;
    start_due   = 1'b1;
    lines_done  = 0;
  endtask

  // A line start counts only while the recorded total is below the cap.
  task automatic record_line(input int unsigned at, inout result_t r);
    if (lines_done < line_cap) begin
      r.new_line    = 1'b1;
      r.line_offset = at[OFFS_W-1:0];
      r.line_index  = lines_done[LINES_W-1:0];
      lines_done++;
    end
  endtask

  task automatic wrap_step(input logic [7:0] c, input logic last, output result_t r);
    int unsigned cols;
    int unsigned p;
    int unsigned nxt;
    logic [7:0]  ch;
    r    = '0;
    cols = (wrap_cols == 0) ? 1 : wrap_cols;
    // Bytes at or past the buffer limit leave the state alone.
    if (text_pos < TEXT_LIMIT) begin
      p  = text_pos;
      ch = (c == CHAR_CR) ? CHAR_SP : c;
      if (start_due) begin
        start_due   = 1'b0;
        line_base   = p;
        space_found = 1'b0;
        space_pos   = 0;
        record_line(p, r);
      end
      if (ch == CHAR_NL) begin
        start_due = 1'b1;
      end else begin
        if (ch == CHAR_SP) begin
          space_pos   = p;
          space_found = 1'b1;
        end
        if (p - line_base >= cols) begin
          nxt = p;
          if (space_found && (p - space_pos) < cols / 2)
            nxt = space_pos + 1;
          // When the wrapping byte is itself the space, the next byte opens the line.
          if (nxt > p) begin
            start_due = 1'b1;
          end else begin
            line_base   = nxt;
            space_found = 1'b0;
            space_pos   = 0;
            record_line(nxt, r);
          end
        end
      end
      text_pos = p + 1;
    end
    if (last) begin
      r.end_of_text = 1'b1;
      r.line_count  = lines_done[LINES_W-1:0];
      restart_text();
    end
  endtask

  initial begin
    wrap_cols = WRAP_COLUMNS_RESET;
    line_cap  = MAX_LINES_RESET;
    restart_text();
  end

  // ---------------------------------------------------------------------------
  // Edge monitor: checks results, predicts from accepted items, tracks register
  // writes and runs the watchdog. One process, so the order within a step is fixed.
  // ---------------------------------------------------------------------------
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned starts_seen = 0;
  int unsigned quiet_cycles = 0;
  bit          pin_en = 1'b0;  // the item on the bus carries a typed expectation
  result_t     pin_res = '0;

  always @(posedge clk) begin : edge_monitor
    result_t got;
    result_t want;
    result_t calc;
    bit      moved;
    if (!rst) begin
      moved = 1'b0;
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        results_seen++;
        got.new_line    = m_tuser;
        got.line_offset = m_tdata[17:0];
        got.line_index  = m_tdata[33:18];
        got.line_count  = m_tdata[49:34];
        got.end_of_text = m_tlast;
        if (m_tuser === 1'b1)
          starts_seen++;
        if (line_starts_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: nl=%0d off=%0d idx=%0d eot=%0d cnt=%0d",
                     $time, got.new_line, got.line_offset, got.line_index,
                     got.end_of_text, got.line_count);
        end else begin
          want = line_starts_q.pop_front();
          if (got.new_line !== want.new_line || got.line_offset !== want.line_offset ||
              got.line_index !== want.line_index || got.end_of_text !== want.end_of_text ||
              got.line_count !== want.line_count || m_tdata[55:50] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected nl=%0d off=%0d idx=%0d eot=%0d cnt=%0d",
                       $time, want.new_line, want.line_offset, want.line_index,
                       want.end_of_text, want.line_count);
              $display("%0t:            got nl=%0d off=%0d idx=%0d eot=%0d cnt=%0d pad=%0h",
                       $time, got.new_line, got.line_offset, got.line_index,
                       got.end_of_text, got.line_count, m_tdata[55:50]);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        wrap_step(s_tdata, s_tlast, calc);
        line_starts_q.push_back(pin_en ? pin_res : calc);
      end
      if (cfg_we) begin
        moved = 1'b1;
        if (cfg_index == REG_WRAP_COLUMNS)
          wrap_cols = cfg_data[WRAP_W-1:0];
        else
          line_cap = cfg_data[LINES_W-1:0];
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls on its own pattern; hold_left forces a long hold-off.
  // Modes: 0 always ready, 1 random stalls, 2 a fixed duty pattern.
  // ---------------------------------------------------------------------------
  int unsigned recv_mode = 0;
  int unsigned hold_left = 0;

  initial begin : receiver
    int unsigned tick;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        case (recv_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ((tick % 9) < 5);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  bit          bursty = 1'b0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned texts_sent = 0;
  int unsigned settings_made = 0;

  // Offers one item and returns at the edge where it is accepted. In burst mode a random
  // gap with tvalid low comes before each new burst.
  task automatic send_byte(input logic [7:0] c, input logic last, input bit pinned,
                           input result_t exp);
    int unsigned gap;
    gap = 0;
    if (bursty) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    pin_en   <= pinned;
    pin_res  <= exp;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (last)
      texts_sent++;
  endtask

  // Stops offering and waits until every expected result has come back. Each item gives
  // exactly one result, so the core is idle once the store is empty.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (line_starts_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_made++;
  endtask

  // Text bytes: mostly letters in words, with spaces, carriage returns, newlines and
  // any byte value now and then.
  function automatic logic [7:0] text_char();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60)      return 8'h61 + 8'($urandom_range(0, 25));
    else if (k < 75) return CHAR_SP;
    else if (k < 80) return CHAR_CR;
    else if (k < 87) return CHAR_NL;
    else             return 8'($urandom_range(0, 255));
  endfunction

  // Directed table rows: a register write, or an item with an optional typed expectation.
  typedef struct {
    bit          is_cfg;
    logic        reg_idx;
    logic [15:0] reg_val;
    logic [7:0]  ch;
    logic        last;
    bit          pinned;
    result_t     exp;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic plan_row_t byte_row(input logic [7:0] c, input logic last);
    plan_row_t r;
    r        = '{default: '0};
    r.ch     = c;
    r.last   = last;
    return r;
  endfunction

  function automatic plan_row_t pinned_row(input logic [7:0] c, input logic last,
                                           input logic nl, input int unsigned off,
                                           input int unsigned idx, input logic eot,
                                           input int unsigned cnt);
    plan_row_t r;
    r                 = byte_row(c, last);
    r.pinned          = 1'b1;
    r.exp.new_line    = nl;
    r.exp.line_offset = off[OFFS_W-1:0];
    r.exp.line_index  = idx[LINES_W-1:0];
    r.exp.end_of_text = eot;
    r.exp.line_count  = cnt[LINES_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic idx, input logic [15:0] val);
    plan_row_t r;
    r         = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  initial begin : stimulus
    int unsigned ph;
    int unsigned ph_items;
    int unsigned len;
    int unsigned i;
    logic [7:0]  wrap_sel;
    logic [15:0] cap_sel;
    string       word;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: wrap at 29, cap of 20000. Control bytes, the byte extremes, a carriage
    // return, a newline, an empty line and a one-byte closing line with the count.
    plan.push_back(pinned_row("A", 1'b0, 1'b1, 0, 0, 1'b0, 0));
    plan.push_back(byte_row(8'h00, 1'b0));
    plan.push_back(byte_row(8'hFF, 1'b0));
    plan.push_back(byte_row(CHAR_CR, 1'b0));
    plan.push_back(byte_row(CHAR_SP, 1'b0));
    plan.push_back(byte_row(CHAR_NL, 1'b0));
    plan.push_back(pinned_row("B", 1'b0, 1'b1, 6, 1, 1'b0, 0));
    plan.push_back(byte_row(CHAR_NL, 1'b0));
    plan.push_back(pinned_row(CHAR_NL, 1'b0, 1'b1, 8, 2, 1'b0, 0));
    plan.push_back(pinned_row("x", 1'b1, 1'b1, 9, 3, 1'b1, 4));
    // Narrow wrap with a cap of three lines: a space as the wrapping byte, a forced break,
    // then a break that the cap suppresses.
    plan.push_back(reg_row(REG_WRAP_COLUMNS, 16'd4));
    plan.push_back(reg_row(REG_MAX_LINES, 16'd3));
    word = "abcd ef ghijkl";
    for (i = 0; i < word.len(); i++)
      plan.push_back(byte_row(word[i], i == word.len() - 1));
    // Zero width acts as one, and a zero cap records nothing.
    plan.push_back(reg_row(REG_WRAP_COLUMNS, 16'd0));
    plan.push_back(reg_row(REG_MAX_LINES, 16'd0));
    plan.push_back(pinned_row("q", 1'b1, 1'b0, 0, 0, 1'b1, 0));

    bursty    = 1'b1;
    recv_mode = 1;
    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        drain();
        cfg_write(plan[n].reg_idx, plan[n].reg_val);
      end else begin
        send_byte(plan[n].ch, plan[n].last, plan[n].pinned, plan[n].exp);
      end
    end

    // Random phases, each with fresh register values written while the core is idle.
    for (ph = 0; ph < 6; ph++) begin
      drain();
      case ($urandom_range(0, 5))
        0:       wrap_sel = 8'd2;
        1:       wrap_sel = 8'd255;
        2:       wrap_sel = 8'($urandom_range(0, 1));
        default: wrap_sel = 8'($urandom_range(3, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       cap_sel = 16'd1;
        1:       cap_sel = 16'd65535;
        2:       cap_sel = 16'd0;
        3:       cap_sel = 16'($urandom_range(2, 6));
        default: cap_sel = 16'($urandom_range(7, 2000));
      endcase
      cfg_write(REG_WRAP_COLUMNS, {8'd0, wrap_sel});
      cfg_write(REG_MAX_LINES, cap_sel);
      if (ph == 0) begin
        // A stretch with no idling on either side.
        bursty    = 1'b0;
        recv_mode = 0;
      end else begin
        bursty    = ($urandom_range(0, 3) != 0);
        recv_mode = $urandom_range(0, 2);
      end
      if (ph == 3) begin
        // The receiver holds off while the sender keeps offering, so the core backs up.
        bursty = 1'b0;
        @(posedge clk);
        hold_left = 400;
      end
      ph_items = 0;
      while (ph_items < 50) begin
        if (wrap_sel >= 100 && $urandom_range(0, 1) == 1)
          len = $urandom_range(260, 400);
        else
          len = $urandom_range(1, 60);
        for (i = 0; i < len; i++)
          send_byte(text_char(), i == len - 1, 1'b0, '0);
        ph_items += len;
      end
    end

    // One text longer than the buffer limit at full rate: width two runs the line count
    // into the cap, and the bytes past the limit must be ignored until the last one.
    drain();
    cfg_write(REG_WRAP_COLUMNS, 16'd2);
    cfg_write(REG_MAX_LINES, 16'd300);
    bursty    = 1'b0;
    recv_mode = 0;
    for (i = 0; i < TEXT_LIMIT + 8; i++)
      send_byte(text_char(), i == TEXT_LIMIT + 7, 1'b0, '0);

    drain();
    repeat (8) @(posedge clk);
    if (line_starts_q.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", line_starts_q.size());
    end
    $display("Sent %0d items in %0d texts under %0d register writes.",
             items_sent, texts_sent, settings_made);
    $display("Checked %0d results, %0d of them line starts; %0d mismatches.",
             results_seen, starts_seen, mismatches);
    if (mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wwl_pkg.sv
hw/rtl/wwl_step.sv
hw/rtl/text_word_wrap_line_indexer_core.sv
sim/tb_top.sv
